### sv/ffba_pkg.sv
// shared widths, codes and controller/datapath interface types of the block allocator
package ffba_pkg;

    localparam int ADDR_W = 32;
    localparam int REQ_W  = 16;
    localparam int STAT_W = 2;

    localparam logic [ADDR_W-1:0] RESET_BASE = 32'hD000_0000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM   = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic init_wr;   // write the whole-arena header at offset 0
        logic take;      // capture the accepted item, start the walk at the head
        logic free_exec; // push a freed block on the list head
        logic rd;        // read the header at the current offset
        logic advance;   // step to the next free block
        logic oom;       // end of walk with nothing found
        logic spl_rest;  // write the remainder header
        logic spl_cur;   // shrink the granted header
        logic link;      // unlink the granted block and set the grant
        logic load_out;  // move the result into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic walk_end;
        logic fits;
        logic split;
        logic out_free;
    } t_sts;

endpackage

### sv/ffba_ctrl.sv
// controller state machine of the block allocator
module ffba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_op,
    input  ffba_pkg::t_sts i_sts,
    output ffba_pkg::t_cmd o_cmd,
    output logic           o_idle
);

    typedef enum logic [8:0] {
        S_INIT = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_FREE = 9'b000000100,
        S_RD   = 9'b000001000,
        S_CHK  = 9'b000010000,
        S_SPL1 = 9'b000100000,
        S_SPL2 = 9'b001000000,
        S_LINK = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = (i_op == ffba_pkg::OP_FREE) ? S_FREE : S_RD;
                end
            end
            S_FREE: begin
                o_cmd.free_exec = 1'b1;
                n_state         = S_DONE;
            end
            S_RD: begin
                if (i_sts.walk_end) begin
                    o_cmd.oom = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (!i_sts.fits) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_RD;
                end else if (i_sts.split) begin
                    n_state = S_SPL1;
                end else begin
                    n_state = S_LINK;
                end
            end
            S_SPL1: begin
                o_cmd.spl_rest = 1'b1;
                n_state        = S_SPL2;
            end
            S_SPL2: begin
                o_cmd.spl_cur = 1'b1;
                n_state       = S_LINK;
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

### sv/ffba_dpath.sv
// datapath of the block allocator: header memory, list pointers, result and output registers
module ffba_dpath #(
    parameter int ARENA_BYTES  = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ffba_pkg::t_cmd                  i_cmd,
    output ffba_pkg::t_sts                  o_sts,
    input  logic                            i_cfg_we,
    input  logic [ffba_pkg::ADDR_W-1:0]     i_cfg_arena_base,
    input  logic [ffba_pkg::REQ_W-1:0]      i_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]     i_block_address,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [ffba_pkg::ADDR_W-1:0]     o_granted_address,
    output logic [ffba_pkg::STAT_W-1:0]     o_status
);

    localparam int AW     = $clog2(ARENA_BYTES);
    localparam int OFF_W  = AW + 1;
    localparam int WIDE_W = ((OFF_W > ffba_pkg::REQ_W + 1) ? OFF_W : ffba_pkg::REQ_W + 1) + 1;

    localparam logic [OFF_W-1:0]           LIST_END = OFF_W'(ARENA_BYTES);
    localparam logic [WIDE_W-1:0]          HDR_W    = WIDE_W'(HEADER_BYTES);
    localparam logic [ffba_pkg::ADDR_W-1:0] HDR_A   = ffba_pkg::ADDR_W'(HEADER_BYTES);

    logic [OFF_W-1:0] size_mem [ARENA_BYTES];
    logic [OFF_W-1:0] next_mem [ARENA_BYTES];

    logic [ffba_pkg::ADDR_W-1:0] r_base;
    logic [OFF_W-1:0]            r_head;
    logic [OFF_W-1:0]            r_cur;
    logic [OFF_W-1:0]            r_prev;
    logic                        r_have_prev;
    logic [OFF_W-1:0]            r_steps;
    logic [ffba_pkg::REQ_W-1:0]  r_req;
    logic [ffba_pkg::ADDR_W-1:0] r_addr;
    logic [OFF_W-1:0]            r_rd_size;
    logic [OFF_W-1:0]            r_rd_next;
    logic [ffba_pkg::ADDR_W-1:0] r_res_addr;
    logic [ffba_pkg::STAT_W-1:0] r_res_status;
    logic                        r_out_valid;
    logic [ffba_pkg::ADDR_W-1:0] r_out_addr;
    logic [ffba_pkg::STAT_W-1:0] r_out_status;

    logic [WIDE_W-1:0]           need;
    logic [WIDE_W-1:0]           rest_wide;
    logic [OFF_W-1:0]            rest;
    logic [OFF_W-1:0]            link_next;
    logic [ffba_pkg::ADDR_W-1:0] free_off;
    logic                        free_in_range;
    logic                        free_zero;

    logic             size_we;
    logic [AW-1:0]    size_wa;
    logic [OFF_W-1:0] size_wd;
    logic             next_we;
    logic [AW-1:0]    next_wa;
    logic [OFF_W-1:0] next_wd;

    assign need      = WIDE_W'(r_req) + HDR_W;
    assign rest_wide = WIDE_W'(r_cur) + need;
    assign rest      = rest_wide[OFF_W-1:0];
    assign link_next = o_sts.split ? rest : r_rd_next;

    assign free_off      = r_addr - r_base - HDR_A;
    assign free_in_range = (free_off < ffba_pkg::ADDR_W'(ARENA_BYTES));
    assign free_zero     = (r_addr == '0);

    assign o_sts.walk_end = (r_cur >= LIST_END) || (r_steps == LIST_END);
    assign o_sts.fits     = (WIDE_W'(r_rd_size) >= need);
    // split only when the remainder header still lies inside the arena
    assign o_sts.split    = (WIDE_W'(r_rd_size) > need + HDR_W)
                            && (rest_wide < WIDE_W'(ARENA_BYTES));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // write port selection
    always_comb begin
        size_we = 1'b0;
        size_wa = '0;
        size_wd = LIST_END;
        next_we = 1'b0;
        next_wa = '0;
        next_wd = LIST_END;
        if (i_cmd.init_wr) begin
            size_we = 1'b1;
            next_we = 1'b1;
        end else if (i_cmd.free_exec) begin
            next_we = !free_zero && free_in_range;
            next_wa = free_off[AW-1:0];
            next_wd = r_head;
        end else if (i_cmd.spl_rest) begin
            size_we = 1'b1;
            size_wa = rest[AW-1:0];
            size_wd = r_rd_size - need[OFF_W-1:0];
            next_we = 1'b1;
            next_wa = rest[AW-1:0];
            next_wd = r_rd_next;
        end else if (i_cmd.spl_cur) begin
            size_we = 1'b1;
            size_wa = r_cur[AW-1:0];
            size_wd = need[OFF_W-1:0];
            next_we = 1'b1;
            next_wa = r_cur[AW-1:0];
            next_wd = rest;
        end else if (i_cmd.link) begin
            next_we = r_have_prev;
            next_wa = r_prev[AW-1:0];
            next_wd = link_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (size_we) begin
            size_mem[size_wa] <= size_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_size <= size_mem[r_cur[AW-1:0]];
            r_rd_next <= next_mem[r_cur[AW-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= ffba_pkg::RESET_BASE;
            r_head      <= '0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_arena_base;
            end
            if (i_cmd.take) begin
                r_have_prev <= 1'b0;
            end else if (i_cmd.advance) begin
                r_have_prev <= 1'b1;
            end
            if (i_cmd.free_exec && !free_zero && free_in_range) begin
                r_head <= free_off[OFF_W-1:0];
            end else if (i_cmd.link && !r_have_prev) begin
                r_head <= link_next;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk pointers and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req   <= i_request_size;
            r_addr  <= i_block_address;
            r_cur   <= r_head;
            r_steps <= '0;
        end else if (i_cmd.advance) begin
            r_prev  <= r_cur;
            r_cur   <= r_rd_next;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.free_exec) begin
            r_res_addr   <= '0;
            r_res_status <= (!free_zero && !free_in_range) ? ffba_pkg::ST_RANGE
                                                           : ffba_pkg::ST_DONE;
        end else if (i_cmd.oom) begin
            r_res_addr   <= '0;
            r_res_status <= ffba_pkg::ST_OOM;
        end else if (i_cmd.link) begin
            r_res_addr   <= r_base + ffba_pkg::ADDR_W'(r_cur) + HDR_A;
            r_res_status <= ffba_pkg::ST_DONE;
        end
        if (i_cmd.load_out) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_granted_address = r_out_addr;
    assign o_status          = r_out_status;

endmodule

### sv/first_fit_block_allocator.sv
// top level of the first-fit free-list block allocator
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_operation, i_request_size, i_block_address
//  out       output     o_out_valid / i_out_stall o_granted_address, o_status
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_arena_base
//
// a free passes through the free state to the done state; an allocate reads one header
// per walk step (grant or out of memory), and writes two headers more when the block is split
// the next transfer can follow in the cycle after the result is loaded
// after reset a one-cycle pass writes the whole-arena header at offset 0; input and
// configuration are held off until the controller is idle, and a finished result
// waits in the output register while the next item is taken

module first_fit_block_allocator #(
    parameter int ARENA_BYTES  = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_operation,
    input  logic [ffba_pkg::REQ_W-1:0]      i_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0]     i_block_address,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ffba_pkg::ADDR_W-1:0]     o_granted_address,
    output logic [ffba_pkg::STAT_W-1:0]     o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ffba_pkg::ADDR_W-1:0]     i_cfg_arena_base
);

    ffba_pkg::t_cmd cmd;
    ffba_pkg::t_sts sts;
    logic           idle;

    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_operation),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    ffba_dpath #(
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_arena_base  (i_cfg_arena_base),
        .i_request_size    (i_request_size),
        .i_block_address   (i_block_address),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_granted_address (o_granted_address),
        .o_status          (o_status)
    );

    assign o_in_stall  = !idle;
    // base only changes while no item is in work
    assign o_cfg_ready = idle;

endmodule

### sv/ffba_checker.sv
// port-level checker of the block allocator and its bind
module ffba_port_checks (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            i_operation,
    input logic [ffba_pkg::REQ_W-1:0]      i_request_size,
    input logic [ffba_pkg::ADDR_W-1:0]     i_block_address,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [ffba_pkg::ADDR_W-1:0]     o_granted_address,
    input logic [ffba_pkg::STAT_W-1:0]     o_status,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [ffba_pkg::ADDR_W-1:0]     i_cfg_arena_base
);

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one item at a time: the input is held off right after a transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in work");

    // a failed request (out of memory or out of range) never carries an address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ffba_pkg::ST_DONE) |-> (o_granted_address == '0))
        else $error("address given with a failure status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ffba_pkg::ST_DONE || o_status == ffba_pkg::ST_OOM
                         || o_status == ffba_pkg::ST_RANGE))
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_granted_address) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind first_fit_block_allocator ffba_port_checks u_ffba_port_checks (.*);

### sim/ffba_checker.sv
// checker for the block allocator: predicts every transfer's result and compares it
module ffba_checker #(
    parameter int ARENA_BYTES  = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_operation,
    input  logic [ffba_pkg::REQ_W-1:0]  i_request_size,
    input  logic [ffba_pkg::ADDR_W-1:0] i_block_address,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [ffba_pkg::ADDR_W-1:0] i_granted_address,
    input  logic [ffba_pkg::STAT_W-1:0] i_status,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [ffba_pkg::ADDR_W-1:0] i_cfg_arena_base,
    output int                          o_errors,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit [31:0] ARENA  = ARENA_BYTES;
    localparam bit [31:0] HEADER = HEADER_BYTES;

    typedef struct packed {
        logic [ffba_pkg::ADDR_W-1:0] addr;
        logic [ffba_pkg::STAT_W-1:0] status;
    } t_grant;

    bit [31:0]   hdr_size [ARENA_BYTES];
    bit [31:0]   hdr_next [ARENA_BYTES];
    bit [31:0]   free_head;
    bit [31:0]   arena_base;
    t_grant      pending_grants[$];
    int          fail_count = 0;

    assign o_errors = fail_count;

    task automatic predict_grant(input logic op, input logic [ffba_pkg::REQ_W-1:0] req,
                                 input logic [ffba_pkg::ADDR_W-1:0] addr,
                                 output logic [ffba_pkg::ADDR_W-1:0] granted,
                                 output logic [ffba_pkg::STAT_W-1:0] status);
        bit [31:0]   need;
        bit [31:0]   cur;
        bit [31:0]   prev;
        bit [31:0]   rest;
        bit [31:0]   off;
        bit          have_prev;
        int unsigned steps;
        granted = '0;
        status  = ffba_pkg::ST_DONE;
        if (op == ffba_pkg::OP_ALLOC) begin
            need      = 32'(req) + HEADER;
            cur       = free_head;
            prev      = ARENA;
            have_prev = 1'b0;
            steps     = 0;
            status    = ffba_pkg::ST_OOM;
            // the visit bound stops a walk round a cyclic list
            while (cur < ARENA && steps < ARENA_BYTES) begin
                if (hdr_size[cur] >= need) begin
                    if (hdr_size[cur] > need + HEADER) begin
                        rest = cur + need;
                        if (rest < ARENA) begin
                            hdr_size[rest] = hdr_size[cur] - need;
                            hdr_next[rest] = hdr_next[cur];
                            hdr_size[cur]  = need;
                            hdr_next[cur]  = rest;
                        end
                    end
                    if (have_prev)
                        hdr_next[prev] = hdr_next[cur];
                    else
                        free_head = hdr_next[cur];
                    granted = arena_base + cur + HEADER;
                    status  = ffba_pkg::ST_DONE;
                    break;
                end
                prev      = cur;
                have_prev = 1'b1;
                cur       = hdr_next[cur];
                steps++;
            end
        end else if (addr != '0) begin
            off = addr - arena_base - HEADER;
            if (off < ARENA) begin
                hdr_next[off] = free_head;
                free_head     = off;
            end else begin
                status = ffba_pkg::ST_RANGE;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_grant                      got;
        t_grant                      want;
        logic [ffba_pkg::ADDR_W-1:0] g_addr;
        logic [ffba_pkg::STAT_W-1:0] g_status;
        if (!i_rst_n) begin
            arena_base  = ffba_pkg::RESET_BASE;
            hdr_size[0] = ARENA;
            hdr_next[0] = ARENA;
            free_head   = '0;
            pending_grants.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                arena_base = i_cfg_arena_base;
            if (i_out_valid && !i_out_stall) begin
                got.addr   = i_granted_address;
                got.status = i_status;
                if (pending_grants.size() == 0) begin
                    $error("result transfer with no expected result waiting: addr %h status %0d",
                           got.addr, got.status);
                    fail_count++;
                end else begin
                    want = pending_grants.pop_front();
                    if (got.addr !== want.addr) begin
                        $error("granted_address: expected %h, actual %h", want.addr, got.addr);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_grant(i_operation, i_request_size, i_block_address, g_addr, g_status);
                want.addr   = g_addr;
                want.status = g_status;
                pending_grants.push_back(want);
            end
            o_pending <= pending_grants.size();
        end
    end

endmodule

### sim/tb_top.sv
// stimulus and verdict for the first-fit block allocator
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ARENA_BYTES  = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int PHASE_ITEMS  = 110;
    localparam int SETTLE       = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 10_000_000;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        operation = ffba_pkg::OP_ALLOC;
    logic [ffba_pkg::REQ_W-1:0]  request_size = '0;
    logic [ffba_pkg::ADDR_W-1:0] block_address = '0;
    logic                        out_stall = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic [ffba_pkg::ADDR_W-1:0] cfg_arena_base = '0;
    logic                        in_stall;
    logic                        out_valid;
    logic [ffba_pkg::ADDR_W-1:0] granted_address;
    logic [ffba_pkg::STAT_W-1:0] status;
    logic                        cfg_ready;
    int                          fail_count;
    int                          pending;

    logic                        quiet = 1'b0;
    logic                        hold_go = 1'b0;
    logic [ffba_pkg::ADDR_W-1:0] cur_base = ffba_pkg::RESET_BASE;
    logic [ffba_pkg::ADDR_W-1:0] live_blocks[$];
    int                          cycle_count = 0;

    always #6 clk = ~clk;

    first_fit_block_allocator #(
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_operation       (operation),
        .i_request_size    (request_size),
        .i_block_address   (block_address),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_granted_address (granted_address),
        .o_status          (status),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_arena_base  (cfg_arena_base)
    );

    ffba_checker #(
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_operation       (operation),
        .i_request_size    (request_size),
        .i_block_address   (block_address),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_granted_address (granted_address),
        .i_status          (status),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_arena_base  (cfg_arena_base),
        .o_errors          (fail_count),
        .o_pending         (pending)
    );

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // outputs are stable at the falling edge, so a grant seen here transfers at the next edge
    always @(negedge clk) begin
        logic [ffba_pkg::ADDR_W-1:0] off;
        if (rst_n && out_valid && !out_stall && status == ffba_pkg::ST_DONE
            && granted_address != '0) begin
            off = granted_address - cur_base - 32'(HEADER_BYTES);
            if (off < 32'(ARENA_BYTES))
                live_blocks.push_back(off);
        end
    end

    initial begin : receiver
        int n;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go && !hold_done) begin
                // long hold-off so the block fills up and stalls its input
                hold_done = 1'b1;
                out_stall <= 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= !quiet && ($urandom_range(0, 99) < 30);
            end
        end
    end

    task automatic send_item(input logic op, input logic [ffba_pkg::REQ_W-1:0] req,
                             input logic [ffba_pkg::ADDR_W-1:0] addr);
        if (!quiet && $urandom_range(0, 99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (!quiet && $urandom_range(0, 99) < 30)
                @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        request_size  <= req;
        block_address <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_base(input logic [ffba_pkg::ADDR_W-1:0] value);
        wait_idle();
        cfg_valid      <= 1'b1;
        cfg_arena_base <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_base = value;
    endtask

    function automatic logic [ffba_pkg::ADDR_W-1:0] outside_address();
        logic [ffba_pkg::ADDR_W-1:0] a;
        a = $urandom;
        if (a - cur_base - 32'(HEADER_BYTES) < 32'(ARENA_BYTES))
            a = cur_base + 32'(HEADER_BYTES + ARENA_BYTES) + $urandom_range(0, 32'h7FFF_FFFF);
        return a;
    endfunction

    task automatic free_live();
        int unsigned                 idx;
        logic [ffba_pkg::ADDR_W-1:0] off;
        if (live_blocks.size() == 0) begin
            send_item(ffba_pkg::OP_FREE, 16'($urandom), '0);
        end else begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            off = live_blocks[idx];
            live_blocks.delete(idx);
            send_item(ffba_pkg::OP_FREE, 16'($urandom), cur_base + off + 32'(HEADER_BYTES));
        end
    endtask

    task automatic random_item();
        int unsigned                pick;
        int unsigned                free_pct;
        logic [ffba_pkg::REQ_W-1:0] req;
        pick     = $urandom_range(0, 99);
        free_pct = (live_blocks.size() > 24) ? 60 : 35;
        if (pick < 8) begin
            // noise: frees the block has to ignore or reject
            if (pick == 0)
                send_item(ffba_pkg::OP_FREE, 16'($urandom), '0);
            else
                send_item(ffba_pkg::OP_FREE, 16'($urandom), outside_address());
        end else if (pick < 8 + free_pct && live_blocks.size() > 0) begin
            free_live();
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                req = 16'($urandom_range(0, 48));
            else if (pick < 90)
                req = 16'($urandom_range(49, 600));
            else if (pick < 95)
                req = 16'($urandom_range(4000, 4100));
            else
                req = 16'($urandom);
            send_item(ffba_pkg::OP_ALLOC, req, $urandom);
        end
    endtask

    initial begin : stimulus
        logic [ffba_pkg::ADDR_W-1:0] phase_base [5];
        logic [ffba_pkg::ADDR_W-1:0] loop_off;
        int                          p;
        int                          k;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // whole arena taken in one exact fit, then the list is empty
        send_item(ffba_pkg::OP_ALLOC, 16'(ARENA_BYTES - HEADER_BYTES), $urandom);
        wait_idle();
        send_item(ffba_pkg::OP_ALLOC, 16'd0, $urandom);
        send_item(ffba_pkg::OP_FREE, 16'($urandom), '0);
        send_item(ffba_pkg::OP_FREE, 16'($urandom), 32'hFFFF_FFFF);
        // header offset wraps below the arena start
        send_item(ffba_pkg::OP_FREE, 16'($urandom), cur_base);
        send_item(ffba_pkg::OP_FREE, 16'($urandom),
                  cur_base + 32'(HEADER_BYTES + ARENA_BYTES));
        free_live();
        // one byte short of the split threshold: granted whole
        send_item(ffba_pkg::OP_ALLOC, 16'(ARENA_BYTES - 2 * HEADER_BYTES), $urandom);
        wait_idle();
        free_live();
        // largest request that still splits, leaving a tiny tail block
        send_item(ffba_pkg::OP_ALLOC, 16'(ARENA_BYTES - 2 * HEADER_BYTES - 1), $urandom);
        wait_idle();
        free_live();
        send_item(ffba_pkg::OP_ALLOC, 16'hFFFF, $urandom);
        send_item(ffba_pkg::OP_ALLOC, 16'(ARENA_BYTES), $urandom);
        send_item(ffba_pkg::OP_ALLOC, 16'd1, $urandom);
        send_item(ffba_pkg::OP_ALLOC, 16'd0, $urandom);
        send_item(ffba_pkg::OP_ALLOC, 16'd3, $urandom);
        send_item(ffba_pkg::OP_ALLOC, 16'd9, $urandom);
        wait_idle();
        free_live();
        free_live();
        free_live();

        phase_base[0] = 32'h0000_0000;
        phase_base[1] = 32'hFFFF_FFFF;
        phase_base[2] = 32'hFFFF_F000;   // grants wrap past the top of the address space
        phase_base[3] = $urandom;
        phase_base[4] = ffba_pkg::RESET_BASE;
        for (p = 0; p < 5; p++) begin
            write_base(phase_base[p]);
            if (p == 1)
                hold_go <= 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 3 && k == 0)
                    quiet <= 1'b1;
                if (p == 3 && k == 60)
                    quiet <= 1'b0;
                random_item();
            end
        end

        // double free turns a block into a self loop; the walk has to give up
        wait_idle();
        if (live_blocks.size() > 0) begin
            loop_off = live_blocks[0];
            send_item(ffba_pkg::OP_FREE, 16'($urandom),
                      cur_base + loop_off + 32'(HEADER_BYTES));
            send_item(ffba_pkg::OP_FREE, 16'($urandom),
                      cur_base + loop_off + 32'(HEADER_BYTES));
            send_item(ffba_pkg::OP_ALLOC, 16'hFFFF, $urandom);
            send_item(ffba_pkg::OP_ALLOC, 16'd0, $urandom);
        end

        wait_idle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
